// ----- hw/rtl/agap_pkg.sv -----
// ----------------------------------------------------------------------------
// agap_pkg
// shared constants, codes and types of the aligned gap allocator
// ----------------------------------------------------------------------------
package agap_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int ADDR_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam logic [ADDR_WIDTH-1:0] MIN_ALIGN = ADDR_WIDTH'(8);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_BADALIGN = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [0:0] CFG_REGION_BASE = 1'b0;
  localparam logic [0:0] CFG_REGION_SIZE = 1'b1;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] base;
    logic [ADDR_WIDTH-1:0] size;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_A_RD, S_A_SUM, S_A_ALN, S_A_FIT, S_RB_SUM,
    S_I_RD, S_I_WR, S_I_PUT, S_F_RD, S_F_CMP, S_D_RD, S_D_WR, S_RESP
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_DECODE, OP_A_RD, OP_A_SUM, OP_A_ALN, OP_A_FIT, OP_RB_SUM,
    OP_I_RD, OP_I_WR, OP_I_PUT, OP_F_RD, OP_F_CMP, OP_D_RD, OP_D_WR, OP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic is_alloc;
    logic is_free;
    logic is_query;
    logic bad_align;
    logic full;
    logic count_zero;
    logic fit;
    logic dup;
    logic rb;
    logic idx_zero;
    logic ins_first;
    logic ins_more;
    logic match;
    logic more;
  } dp_stat_t;

endpackage

// ----- hw/rtl/agap_if.sv -----
// ----------------------------------------------------------------------------
// agap request and response channels
// valid/ready channels carrying allocator requests and responses
// ----------------------------------------------------------------------------
interface agap_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic [agap_pkg::ADDR_WIDTH-1:0] req_size;
  logic [agap_pkg::ADDR_WIDTH-1:0] req_alignment;
  logic [agap_pkg::ADDR_WIDTH-1:0] block_address;

  modport source (output valid, req_type, req_size, req_alignment, block_address,
                  input ready);
  modport sink   (input valid, req_type, req_size, req_alignment, block_address,
                  output ready);
endinterface

interface agap_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      status;
  logic [agap_pkg::ADDR_WIDTH-1:0] result_address;
  logic [agap_pkg::ADDR_WIDTH-1:0] result_size;

  modport source (output valid, status, result_address, result_size, input ready);
  modport sink   (input valid, status, result_address, result_size, output ready);
endinterface

// ----- hw/rtl/agap_ram.sv -----
// ----------------------------------------------------------------------------
// agap_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module agap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/agap_ctrl.sv -----
// ----------------------------------------------------------------------------
// agap_ctrl
// sequencer for allocate, free and query requests
// ----------------------------------------------------------------------------
module agap_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  agap_pkg::dp_stat_t stat,
  output agap_pkg::dp_cmd_t  cmd
);

  agap_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= agap_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      agap_pkg::S_IDLE: begin
        if (stat.in_valid) state_nxt = agap_pkg::S_DECODE;
      end
      agap_pkg::S_DECODE: begin
        priority if (stat.is_alloc) begin
          priority if (stat.bad_align || stat.full) state_nxt = agap_pkg::S_RESP;
          else if (stat.count_zero)                 state_nxt = agap_pkg::S_RB_SUM;
          else                                      state_nxt = agap_pkg::S_A_RD;
        end else if (stat.is_free || stat.is_query) begin
          state_nxt = stat.count_zero ? agap_pkg::S_RESP : agap_pkg::S_F_RD;
        end else begin
          state_nxt = agap_pkg::S_RESP;
        end
      end
      agap_pkg::S_A_RD:   state_nxt = agap_pkg::S_A_SUM;
      agap_pkg::S_A_SUM:  state_nxt = agap_pkg::S_A_ALN;
      agap_pkg::S_RB_SUM: state_nxt = agap_pkg::S_A_ALN;
      agap_pkg::S_A_ALN:  state_nxt = agap_pkg::S_A_FIT;
      agap_pkg::S_A_FIT: begin
        priority if (stat.fit) begin
          priority if (stat.dup)       state_nxt = agap_pkg::S_RESP;
          else if (stat.ins_first)     state_nxt = agap_pkg::S_I_RD;
          else                         state_nxt = agap_pkg::S_I_PUT;
        end else if (stat.rb) begin
          state_nxt = agap_pkg::S_RESP;
        end else if (stat.idx_zero) begin
          state_nxt = agap_pkg::S_RB_SUM;
        end else begin
          state_nxt = agap_pkg::S_A_RD;
        end
      end
      agap_pkg::S_I_RD: state_nxt = agap_pkg::S_I_WR;
      agap_pkg::S_I_WR: begin
        state_nxt = stat.ins_more ? agap_pkg::S_I_RD : agap_pkg::S_I_PUT;
      end
      agap_pkg::S_I_PUT: state_nxt = agap_pkg::S_RESP;
      agap_pkg::S_F_RD:  state_nxt = agap_pkg::S_F_CMP;
      agap_pkg::S_F_CMP: begin
        priority if (stat.match && stat.is_query) state_nxt = agap_pkg::S_RESP;
        else if (stat.more)                       state_nxt = stat.match ? agap_pkg::S_D_RD
                                                                          : agap_pkg::S_F_RD;
        else                                      state_nxt = agap_pkg::S_RESP;
      end
      agap_pkg::S_D_RD: state_nxt = agap_pkg::S_D_WR;
      agap_pkg::S_D_WR: begin
        state_nxt = stat.more ? agap_pkg::S_D_RD : agap_pkg::S_RESP;
      end
      agap_pkg::S_RESP: begin
        if (stat.out_free) state_nxt = agap_pkg::S_IDLE;
      end
      default: state_nxt = agap_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      agap_pkg::S_IDLE:   cmd.op = agap_pkg::OP_IDLE;
      agap_pkg::S_DECODE: cmd.op = agap_pkg::OP_DECODE;
      agap_pkg::S_A_RD:   cmd.op = agap_pkg::OP_A_RD;
      agap_pkg::S_A_SUM:  cmd.op = agap_pkg::OP_A_SUM;
      agap_pkg::S_A_ALN:  cmd.op = agap_pkg::OP_A_ALN;
      agap_pkg::S_A_FIT:  cmd.op = agap_pkg::OP_A_FIT;
      agap_pkg::S_RB_SUM: cmd.op = agap_pkg::OP_RB_SUM;
      agap_pkg::S_I_RD:   cmd.op = agap_pkg::OP_I_RD;
      agap_pkg::S_I_WR:   cmd.op = agap_pkg::OP_I_WR;
      agap_pkg::S_I_PUT:  cmd.op = agap_pkg::OP_I_PUT;
      agap_pkg::S_F_RD:   cmd.op = agap_pkg::OP_F_RD;
      agap_pkg::S_F_CMP:  cmd.op = agap_pkg::OP_F_CMP;
      agap_pkg::S_D_RD:   cmd.op = agap_pkg::OP_D_RD;
      agap_pkg::S_D_WR:   cmd.op = agap_pkg::OP_D_WR;
      agap_pkg::S_RESP:   cmd.op = agap_pkg::OP_RESP;
      default:            cmd.op = agap_pkg::OP_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/agap_dp.sv -----
// ----------------------------------------------------------------------------
// agap_dp
// block table, gap arithmetic, request and response registers
// ----------------------------------------------------------------------------
module agap_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  agap_req_if.sink                        in_ch,
  agap_rsp_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [agap_pkg::ADDR_WIDTH-1:0] cfg_data,
  input  agap_pkg::dp_cmd_t               cmd,
  output agap_pkg::dp_stat_t              stat
);

  localparam int AW = agap_pkg::ADDR_WIDTH;
  localparam int CW = agap_pkg::CNT_W;
  localparam int IW = agap_pkg::IDX_W;

  logic [AW-1:0] rb_r, rsize_r;
  logic [1:0]    type_r;
  logic [AW-1:0] size_r, al_r, addr_r;
  logic [CW-1:0] count_r, idx_r, pos_r;
  logic [AW:0]   v_r;
  logic [AW-1:0] s_r, end_r, cur_base_r;
  logic          ok_r, end_is_base_r, rb_phase_r;
  logic [2:0]    res_status_r;
  logic [AW-1:0] res_addr_r, res_size_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [AW-1:0] out_addr_r, out_size_r;

  agap_pkg::entry_t rdata, wdata;
  logic             we;
  logic [IW-1:0]    waddr, raddr;

  logic [AW-1:0] al_m1;
  logic [AW:0]   top_sum, diff;
  logic [AW+1:0] aln_sum;
  logic [CW-1:0] idx_inc, idx_dec, pos_c;
  logic          fit, dup, more, match, out_free;

  assign al_m1   = al_r - AW'(1);
  assign top_sum = {1'b0, rb_r} + {1'b0, rsize_r};
  assign aln_sum = {1'b0, v_r} + {2'b00, al_m1};
  assign diff    = {1'b0, end_r} - {1'b0, s_r};
  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);
  assign pos_c   = rb_phase_r ? '0 : idx_inc;
  assign fit     = ok_r && !diff[AW] && (diff[AW-1:0] >= size_r);
  assign dup     = (!rb_phase_r && (s_r == cur_base_r)) || (end_is_base_r && (s_r == end_r));
  assign more    = idx_inc < count_r;
  assign match   = rdata.base == addr_r;
  assign out_free = !out_valid_r || out_ch.ready;

  assign raddr = (cmd.op == agap_pkg::OP_I_RD) ? idx_dec[IW-1:0] : idx_r[IW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[IW-1:0];
    wdata = rdata;
    unique case (cmd.op)
      agap_pkg::OP_I_WR: we = 1'b1;
      agap_pkg::OP_I_PUT: begin
        we    = 1'b1;
        waddr = pos_r[IW-1:0];
        wdata = '{base: s_r, size: size_r};
      end
      agap_pkg::OP_D_WR: begin
        we    = 1'b1;
        waddr = idx_dec[IW-1:0];
      end
      default: we = 1'b0;
    endcase
  end

  agap_ram #(
    .WIDTH($bits(agap_pkg::entry_t)),
    .DEPTH(agap_pkg::MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r    <= '0;
      rsize_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        agap_pkg::CFG_REGION_BASE: rb_r    <= cfg_data;
        agap_pkg::CFG_REGION_SIZE: rsize_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == agap_pkg::OP_I_PUT) begin
        count_r <= count_r + CW'(1);
      end
      if (((cmd.op == agap_pkg::OP_F_CMP && match && type_r == agap_pkg::REQ_FREE) ||
           cmd.op == agap_pkg::OP_D_WR) && !more) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.op == agap_pkg::OP_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      agap_pkg::OP_IDLE: begin
        if (in_ch.valid) begin
          type_r       <= in_ch.req_type;
          size_r       <= in_ch.req_size;
          al_r         <= (in_ch.req_alignment < agap_pkg::MIN_ALIGN) ? agap_pkg::MIN_ALIGN
                                                                      : in_ch.req_alignment;
          addr_r       <= in_ch.block_address;
          res_status_r <= agap_pkg::ST_OK;
          res_addr_r   <= '0;
          res_size_r   <= '0;
        end
      end
      agap_pkg::OP_DECODE: begin
        rb_phase_r    <= 1'b0;
        end_is_base_r <= 1'b0;
        end_r         <= top_sum[AW] ? '1 : top_sum[AW-1:0];
        priority if (type_r == agap_pkg::REQ_ALLOC) begin
          idx_r <= count_r - CW'(1);
          priority if (stat.bad_align)   res_status_r <= agap_pkg::ST_BADALIGN;
          else if (stat.full)            res_status_r <= agap_pkg::ST_FULL;
          else                           res_status_r <= agap_pkg::ST_OK;
        end else if (type_r == agap_pkg::REQ_FREE || type_r == agap_pkg::REQ_QUERY) begin
          idx_r <= '0;
          if (count_r == '0) res_status_r <= agap_pkg::ST_NOTFOUND;
        end else begin
          res_status_r <= agap_pkg::ST_NOTFOUND;
        end
      end
      agap_pkg::OP_A_SUM: begin
        v_r        <= {1'b0, rdata.base} + {1'b0, rdata.size};
        cur_base_r <= rdata.base;
      end
      agap_pkg::OP_RB_SUM: begin
        v_r        <= {1'b0, rb_r};
        rb_phase_r <= 1'b1;
      end
      agap_pkg::OP_A_ALN: begin
        ok_r <= aln_sum[AW+1:AW] == 2'b00;
        s_r  <= aln_sum[AW-1:0] & ~al_m1;
      end
      agap_pkg::OP_A_FIT: begin
        if (fit) begin
          res_addr_r <= s_r;
          pos_r      <= pos_c;
          idx_r      <= count_r;
        end else begin
          end_r         <= cur_base_r;
          end_is_base_r <= 1'b1;
          idx_r         <= idx_dec;
          if (rb_phase_r) res_status_r <= agap_pkg::ST_NOSPACE;
        end
      end
      agap_pkg::OP_I_WR: idx_r <= idx_dec;
      agap_pkg::OP_F_CMP: begin
        idx_r <= idx_inc;
        if (match) begin
          if (type_r == agap_pkg::REQ_QUERY) res_size_r <= rdata.size;
        end else if (!more) begin
          res_status_r <= agap_pkg::ST_NOTFOUND;
        end
      end
      agap_pkg::OP_D_WR: idx_r <= idx_inc;
      agap_pkg::OP_RESP: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_addr_r   <= res_addr_r;
          out_size_r   <= res_size_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready           = cmd.op == agap_pkg::OP_IDLE;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.result_size    = out_size_r;

  always_comb begin
    stat.in_valid   = in_ch.valid;
    stat.out_free   = out_free;
    stat.is_alloc   = type_r == agap_pkg::REQ_ALLOC;
    stat.is_free    = type_r == agap_pkg::REQ_FREE;
    stat.is_query   = type_r == agap_pkg::REQ_QUERY;
    stat.bad_align  = (al_r & al_m1) != '0;
    stat.full       = count_r == CW'(agap_pkg::MAX_BLOCKS);
    stat.count_zero = count_r == '0;
    stat.fit        = fit;
    stat.dup        = dup;
    stat.rb         = rb_phase_r;
    stat.idx_zero   = idx_r == '0;
    stat.ins_first  = count_r > pos_c;
    stat.ins_more   = idx_dec > pos_r;
    stat.match      = match;
    stat.more       = more;
  end

endmodule

// ----- hw/rtl/aligned_gap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// aligned_gap_allocator_top
// aligned allocator over one region with a sorted table of blocks
//
//   channel   role    transfer
//   in_ch     sink    request: type, size, alignment, block address
//   out_ch    source  response: status, address, size
//   cfg_*     write   region base (index 0), region size (index 1)
//
// one request at a time; each request is decoded, then answered in the response state
// allocate scans the table top down (read, sum, align, fit per block), then
// moves the blocks above the insert point up by one (read, write each); free
// and query scan bottom up (read, compare per block) and a free moves the blocks above down by one
// reset empties the table at once; a stalled response holds the next request
// ----------------------------------------------------------------------------
module aligned_gap_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  agap_req_if.sink                        in_ch,
  agap_rsp_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [agap_pkg::ADDR_WIDTH-1:0] cfg_data
);

  agap_pkg::dp_cmd_t  cmd;
  agap_pkg::dp_stat_t stat;

  agap_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .cmd  (cmd)
  );

  agap_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
